// File: rtl/skhst_pkg.sv
// Shared constants and types for the string key hash slot table.
// No dependencies; the top level takes everything here by scoped name.
package skhst_pkg;

  // Fixed field widths of the command and result words
  localparam int CHAR_W       = 8;
  localparam int SLOT_OUT_W   = 7;
  localparam int STATUS_W     = 3;
  localparam int COUNT_OUT_W  = 7;

  // Defaults for the top-level parameters
  localparam int DEF_TABLE_SLOTS   = 101;
  localparam int DEF_MAX_KEY_CHARS = 15;

  // Multiplier applied to the remainder of the weighted sum before the second slot reduction
  localparam int HASH_MULT = 19;

  // Action codes
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_ADD_BUSY  = 3'd1,
    ST_DELETED   = 3'd2,
    ST_DEL_EMPTY = 3'd3,
    ST_OVERLONG  = 3'd4
  } status_t;

  // Control bits that travel down the slot pipeline with each finished key
  typedef struct packed {
    logic vld;
    logic act;
    logic ovl;
  } ctl_t;

endpackage

// File: rtl/string_key_hash_slot_table_unit.sv
// String key hash slot table: accumulates a key one character per word,
// hashes it to a slot and adds or deletes that slot. Depends on skhst_pkg.
//
//  Channel  Handshake                 Payload
//  -------  ------------------------  ------------------------------------------
//  input    start, busy (accept when  in_action, in_key_char, in_last_char
//           start and not busy)
//  result   out_valid (one-cycle      out_slot_index, out_status, out_entry_count
//           strobe, no back-pressure)
//
// One character word is accepted every cycle; busy is high only during reset
// and the first cycle after it. The result for a key is registered through
// the accumulate stage (loaded at the edge that accepts its last character),
// five stages of modulo reduction (two reciprocal multiply / subtract passes)
// and the table update, which raises the result strobe and loads the word.
// The occupancy bits are flip-flops cleared at once by reset; no clearing pass.
// The receiver cannot stall, so nothing ever holds the pipeline.
module string_key_hash_slot_table_unit #(
  parameter int TABLE_SLOTS   = skhst_pkg::DEF_TABLE_SLOTS,
  parameter int MAX_KEY_CHARS = skhst_pkg::DEF_MAX_KEY_CHARS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_action,
  input  logic [skhst_pkg::CHAR_W-1:0]      in_key_char,
  input  logic                             in_last_char,
  output logic                             out_valid,
  output logic [skhst_pkg::SLOT_OUT_W-1:0]  out_slot_index,
  output logic [skhst_pkg::STATUS_W-1:0]    out_status,
  output logic [skhst_pkg::COUNT_OUT_W-1:0] out_entry_count
);

  localparam int CHAR_W     = skhst_pkg::CHAR_W;
  localparam int OUT_SLOT_W = skhst_pkg::SLOT_OUT_W;
  localparam int OUT_CNT_W  = skhst_pkg::COUNT_OUT_W;
  localparam int POS_W      = $clog2(MAX_KEY_CHARS + 2);
  localparam int SUM_MAX    = ((2 ** CHAR_W) - 1) * MAX_KEY_CHARS * (MAX_KEY_CHARS + 1) / 2;
  localparam int SUM_W      = $clog2(SUM_MAX + 1);
  localparam int SLOT_W     = $clog2(TABLE_SLOTS);
  localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
  localparam int R_W        = $clog2(2 * TABLE_SLOTS);
  localparam int X1_W       = (SUM_W > R_W) ? SUM_W : R_W;
  localparam int M1         = (2 ** X1_W) / TABLE_SLOTS;
  localparam int X2_W       = $clog2(skhst_pkg::HASH_MULT * TABLE_SLOTS);
  localparam int M2         = (2 ** X2_W) / TABLE_SLOTS;
  localparam int TERM_W     = CHAR_W + POS_W;
  localparam int LATENCY    = 7;

  // Accept and key accumulation state
  logic                 busy_r;
  logic                 accept;
  logic [SUM_W-1:0]     sum_r;
  logic [POS_W-1:0]     pos_r;
  logic                 ovl;
  logic [TERM_W-1:0]    term;
  logic [SUM_W-1:0]     sum_add;

  // Pipeline stages: control and payload
  skhst_pkg::ctl_t      ctl_r [1:6];
  logic [X1_W-1:0]      s1_sum_r;
  logic [X1_W-1:0]      s2_sum_r;
  logic [X1_W-1:0]      s2_q_r;
  logic [R_W-1:0]       s3_r_r;
  logic [X2_W-1:0]      s4_x_r;
  logic [X2_W-1:0]      s5_x_r;
  logic [X2_W-1:0]      s5_q_r;
  logic [R_W-1:0]       s6_r_r;
  logic [2*X1_W-1:0]    prod1;
  logic [2*X2_W-1:0]    prod2;
  logic [R_W-1:0]       r1_fix;
  logic [R_W-1:0]       r2_fix;

  // Table and result
  logic [TABLE_SLOTS-1:0] used_r;
  logic [TABLE_SLOTS-1:0] used_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_nxt;
  logic [SLOT_W-1:0]      slot;
  logic [SLOT_W-1:0]      slot_res;
  skhst_pkg::status_t     status_nxt;
  logic                   out_valid_r;
  logic [OUT_SLOT_W-1:0]  out_slot_r;
  skhst_pkg::status_t     out_status_r;
  logic [OUT_CNT_W-1:0]   out_cnt_r;

  assign accept  = start && !busy_r;
  assign ovl     = pos_r > POS_W'(MAX_KEY_CHARS);
  assign term    = TERM_W'(in_key_char) * TERM_W'(pos_r);
  assign sum_add = sum_r + SUM_W'(term);

  // Hold busy through reset, then accept a word every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Accumulate the weighted sum; restart on the last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      pos_r <= POS_W'(1);
    end else if (accept) begin
      if (in_last_char) begin
        sum_r <= '0;
        pos_r <= POS_W'(1);
      end else if (!ovl) begin
        sum_r <= sum_add;
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  // Advance control bits down the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 6; i++) begin
        ctl_r[i] <= '0;
      end
    end else begin
      ctl_r[1].vld <= accept && in_last_char;
      ctl_r[1].act <= in_action;
      ctl_r[1].ovl <= ovl;
      for (int i = 2; i <= 6; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  // First reduction: sum mod slots through a reciprocal estimate
  assign prod1  = (2*X1_W)'(s1_sum_r) * (2*X1_W)'(M1);
  assign r1_fix = (s3_r_r >= R_W'(TABLE_SLOTS)) ? s3_r_r - R_W'(TABLE_SLOTS) : s3_r_r;
  // Second reduction: (remainder * multiplier) mod slots
  assign prod2  = (2*X2_W)'(s4_x_r) * (2*X2_W)'(M2);
  assign r2_fix = (s6_r_r >= R_W'(TABLE_SLOTS)) ? s6_r_r - R_W'(TABLE_SLOTS) : s6_r_r;

  always_ff @(posedge clk) begin
    s1_sum_r <= ovl ? '0 : X1_W'(sum_add);
    s2_sum_r <= s1_sum_r;
    s2_q_r   <= X1_W'(prod1 >> X1_W);
    s3_r_r   <= R_W'(s2_sum_r - s2_q_r * X1_W'(TABLE_SLOTS));
    s4_x_r   <= X2_W'(r1_fix) * X2_W'(skhst_pkg::HASH_MULT);
    s5_x_r   <= s4_x_r;
    s5_q_r   <= X2_W'(prod2 >> X2_W);
    s6_r_r   <= R_W'(s5_x_r - s5_q_r * X2_W'(TABLE_SLOTS));
  end

  assign slot = SLOT_W'(r2_fix);

  // Update occupancy and count for the finished key
  always_comb begin
    used_nxt   = used_r;
    cnt_nxt    = cnt_r;
    slot_res   = '0;
    status_nxt = skhst_pkg::ST_OVERLONG;
    if (ctl_r[6].vld && !ctl_r[6].ovl) begin
      slot_res = slot;
      case (ctl_r[6].act)
        skhst_pkg::ACT_ADD: begin
          if (!used_r[slot]) begin
            used_nxt[slot] = 1'b1;
            cnt_nxt        = cnt_r + CNT_W'(1);
            status_nxt     = skhst_pkg::ST_ADDED;
          end else begin
            status_nxt = skhst_pkg::ST_ADD_BUSY;
          end
        end
        skhst_pkg::ACT_DELETE: begin
          if (used_r[slot]) begin
            used_nxt[slot] = 1'b0;
            cnt_nxt        = cnt_r - CNT_W'(1);
            status_nxt     = skhst_pkg::ST_DELETED;
          end else begin
            status_nxt = skhst_pkg::ST_DEL_EMPTY;
          end
        end
        default: begin
          status_nxt = skhst_pkg::ST_OVERLONG;
        end
      endcase
    end
  end

  // Hold the table state and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= ctl_r[6].vld;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (ctl_r[6].vld) begin
      out_slot_r   <= OUT_SLOT_W'(slot_res);
      out_status_r <= status_nxt;
      out_cnt_r    <= OUT_CNT_W'(cnt_nxt);
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_slot_index  = out_slot_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_cnt_r;

  // Entry count always matches the number of occupied slots
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(cnt_r))
    else $error("entry count differs from occupancy");

  // A last character yields a result after the pipeline latency
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_char) |-> ##LATENCY out_valid)
    else $error("result missing for finished key");

  // A result always comes from an accepted last character
  a_result_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_last_char, LATENCY))
    else $error("result without finished key");

  // Refused and overlong operations leave the count unchanged
  a_refusal_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status_r == skhst_pkg::ST_OVERLONG ||
                   out_status_r == skhst_pkg::ST_ADD_BUSY ||
                   out_status_r == skhst_pkg::ST_DEL_EMPTY))
    |-> cnt_r == $past(cnt_r))
    else $error("count changed on refused operation");

endmodule

// File: test/testbench.sv
// Self-checking testbench for string_key_hash_slot_table_unit.
// Streams key characters through the command port and checks every result
// strobe against a local slot-table predictor. Depends on skhst_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS   = skhst_pkg::DEF_TABLE_SLOTS;
  localparam int MAX_KEY_CHARS = skhst_pkg::DEF_MAX_KEY_CHARS;
  localparam int CHAR_W        = skhst_pkg::CHAR_W;
  localparam int SLOT_OUT_W    = skhst_pkg::SLOT_OUT_W;
  localparam int STATUS_W      = skhst_pkg::STATUS_W;
  localparam int COUNT_OUT_W   = skhst_pkg::COUNT_OUT_W;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct {
    logic [SLOT_OUT_W-1:0]  slot;
    skhst_pkg::status_t     status;
    logic [COUNT_OUT_W-1:0] count;
  } slot_result_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   in_action = skhst_pkg::ACT_ADD;
  logic [CHAR_W-1:0]      in_key_char = '0;
  logic                   in_last_char = 1'b0;
  logic                   out_valid;
  logic [SLOT_OUT_W-1:0]  out_slot_index;
  logic [STATUS_W-1:0]    out_status;
  logic [COUNT_OUT_W-1:0] out_entry_count;

  // Predictor state: occupancy, count and the key being accumulated
  bit           slot_full [TABLE_SLOTS];
  int           occupied = 0;
  int           key_sum = 0;
  int           next_pos = 1;
  slot_result_t expected_results [$];

  // Run bookkeeping
  int idle_pct = 0;
  int chars_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int peak_occupied = 0;
  int status_seen [5];

  string_key_hash_slot_table_unit #(
    .TABLE_SLOTS   (TABLE_SLOTS),
    .MAX_KEY_CHARS (MAX_KEY_CHARS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_key_char     (in_key_char),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_slot_index  (out_slot_index),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Accumulate one accepted character; on the last one, update the table
  // and queue the result it must produce
  task automatic hash_char(input logic act, input logic [CHAR_W-1:0] ch, input logic last);
    slot_result_t r;
    bit           too_long;
    int           slot;
    too_long = (next_pos > MAX_KEY_CHARS);
    if (too_long) begin
      next_pos = MAX_KEY_CHARS + 1;
    end else begin
      key_sum += int'(ch) * next_pos;
      next_pos++;
    end
    if (last) begin
      r.slot = '0;
      if (too_long) begin
        r.status = skhst_pkg::ST_OVERLONG;
      end else begin
        slot = (key_sum * skhst_pkg::HASH_MULT) % TABLE_SLOTS;
        r.slot = SLOT_OUT_W'(slot);
        if (act == skhst_pkg::ACT_ADD) begin
          if (!slot_full[slot]) begin
            slot_full[slot] = 1'b1;
            occupied++;
            r.status = skhst_pkg::ST_ADDED;
          end else begin
            r.status = skhst_pkg::ST_ADD_BUSY;
          end
        end else begin
          if (slot_full[slot]) begin
            slot_full[slot] = 1'b0;
            if (occupied > 0) occupied--;
            r.status = skhst_pkg::ST_DELETED;
          end else begin
            r.status = skhst_pkg::ST_DEL_EMPTY;
          end
        end
      end
      r.count = COUNT_OUT_W'(occupied);
      if (occupied > peak_occupied) peak_occupied = occupied;
      key_sum = 0;
      next_pos = 1;
      expected_results.push_back(r);
    end
  endtask

  // Send one character word, idling first at the current rate; the
  // idle cycles carry junk on the payload, which must be ignored
  task automatic send_char(input logic act, input logic [CHAR_W-1:0] ch, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      start        <= 1'b0;
      in_action    <= 1'($urandom);
      in_key_char  <= CHAR_W'($urandom);
      in_last_char <= 1'($urandom);
      @(posedge clk);
    end
    start        <= 1'b1;
    in_action    <= act;
    in_key_char  <= ch;
    in_last_char <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    hash_char(act, ch, last);
    chars_sent++;
  endtask

  // Send a key of len characters; fixed_ch < 0 picks random characters.
  // Action on non-final characters is random since it is ignored there.
  task automatic send_key(input int len, input logic act, input int fixed_ch);
    logic [CHAR_W-1:0] ch;
    for (int i = 0; i < len; i++) begin
      ch = (fixed_ch < 0) ? CHAR_W'($urandom) : CHAR_W'(fixed_ch);
      send_char((i == len - 1) ? act : 1'($urandom), ch, i == len - 1);
    end
  endtask

  // Single-character keys: add, refuse, delete, delete of an empty slot,
  // and delete by a different key that lands on the same slot
  task automatic test_single_char_keys();
    idle_pct = 0;
    send_char(skhst_pkg::ACT_ADD, 8'd0, 1'b1);
    send_char(skhst_pkg::ACT_ADD, 8'd0, 1'b1);
    send_char(skhst_pkg::ACT_DELETE, 8'd0, 1'b1);
    send_char(skhst_pkg::ACT_DELETE, 8'd0, 1'b1);
    send_char(skhst_pkg::ACT_ADD, 8'd5, 1'b1);
    send_char(skhst_pkg::ACT_DELETE, 8'd106, 1'b1);
    send_char(skhst_pkg::ACT_ADD, 8'd255, 1'b1);
  endtask

  // Longest legal key with the largest characters gives the largest sum
  task automatic test_max_length_key();
    idle_pct = 0;
    send_key(MAX_KEY_CHARS, skhst_pkg::ACT_ADD, 255);
  endtask

  // One character past the limit: overlong status, table untouched even
  // though the summed prefix maps to an occupied slot
  task automatic test_overlong_key();
    idle_pct = 12;
    send_key(MAX_KEY_CHARS + 1, skhst_pkg::ACT_DELETE, 255);
  endtask

  // Fill every slot, try once more on a full table, then drain it;
  // single characters 0..100 map one-to-one onto the slots
  task automatic test_fill_and_drain();
    int order [TABLE_SLOTS];
    int j;
    int tmp;
    idle_pct = 12;
    for (int i = 0; i < TABLE_SLOTS; i++) order[i] = i;
    for (int i = TABLE_SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      send_char(skhst_pkg::ACT_ADD, CHAR_W'(order[i]), 1'b1);
    end
    send_char(skhst_pkg::ACT_ADD, CHAR_W'($urandom), 1'b1);
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      send_char(skhst_pkg::ACT_DELETE, CHAR_W'(order[i]), 1'b1);
    end
    send_char(skhst_pkg::ACT_DELETE, CHAR_W'($urandom), 1'b1);
  endtask

  // Random keys, mostly short and legal, a few overlong; each phase sets
  // the idle rate and how strongly actions lean toward add
  task automatic test_random_keys();
    int phase_idle [4] = '{0, 77, 0, 12};
    int phase_add  [4] = '{75, 50, 25, 60};
    int phase_chars[4] = '{500, 500, 400, 600};
    int stop_at;
    int pick;
    int len;
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stop_at = chars_sent + phase_chars[p];
      while (chars_sent < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 85) len = $urandom_range(6, 1);
        else if (pick < 95) len = $urandom_range(MAX_KEY_CHARS, 7);
        else len = $urandom_range(MAX_KEY_CHARS + 5, MAX_KEY_CHARS + 1);
        send_key(len, ($urandom_range(99) < phase_add[p]) ?
                 skhst_pkg::ACT_ADD : skhst_pkg::ACT_DELETE, -1);
      end
    end
  endtask

  // Compare each result strobe with the oldest expectation
  always @(posedge clk) begin : check_results
    slot_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: slot %0d status %0d count %0d",
               out_slot_index, out_status, out_entry_count);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (int'(want.status) < 5) status_seen[int'(want.status)]++;
        if (out_slot_index !== want.slot) begin
          $error("slot_index: expected %0d, actual %0d", want.slot, out_slot_index);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, out_entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) slot_full[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_single_char_keys();
    test_max_length_key();
    test_overlong_key();
    test_fill_and_drain();
    test_random_keys();

    // Drop start, then let the pipeline empty
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d characters, checked %0d results, peak occupancy %0d of %0d slots",
             chars_sent, results_checked, peak_occupied, TABLE_SLOTS);
    $display("statuses: added %0d, add refused %0d, deleted %0d, delete empty %0d, overlong %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/skhst_pkg.sv
rtl/string_key_hash_slot_table_unit.sv
test/testbench.sv
